// File: hw/rtl/cia_pkg.sv
// Shared types, constants and helper functions of the calendar interval adder.
// Used by cia_calc, calendar_interval_add and cia_checker; depends on nothing.
package cia_pkg;

   typedef enum logic [1:0] {
      MODE_DAY    = 2'd0,
      MODE_HOUR   = 2'd1,
      MODE_MINUTE = 2'd2,
      MODE_HOLD   = 2'd3
   } mode_type;

   typedef struct packed {
      logic [6:0] year;
      logic [3:0] month;
      logic [4:0] day;
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
   } date_type;

   typedef struct packed {
      mode_type           mode;
      logic signed [5:0]  interval;
      date_type           date;
   } req_type;

   localparam logic signed [7:0] MINUTES_PER_HOUR = 8'sd60;
   localparam logic signed [7:0] HOURS_PER_DAY    = 8'sd24;
   localparam logic        [6:0] YEAR_MAX         = 7'd99;
   localparam logic        [4:0] DAY_STEP_HOUR    = 5'd8;
   localparam logic        [3:0] MONTH_FIRST      = 4'd1;
   localparam logic        [3:0] MONTH_LAST       = 4'd12;
   localparam logic signed [5:0] MINUTE_STEP_MAX  = 6'sd30;
   localparam logic signed [5:0] HOUR_STEP_MAX    = 6'sd23;
   localparam logic signed [5:0] DAY_STEP_MAX     = 6'sd1;

   // Days in a month; any month code outside 1..12 counts as 31 days.
   function automatic logic [4:0] month_length(input logic [3:0] month, input logic leap);
      logic [4:0] len;
      case (month)
         4'd2:    len = leap ? 5'd29 : 5'd28;
         4'd4:    len = 5'd30;
         4'd6:    len = 5'd30;
         4'd9:    len = 5'd30;
         4'd11:   len = 5'd30;
         default: len = 5'd31;
      endcase
      return len;
   endfunction

   function automatic logic signed [5:0] clamp_step(input logic signed [5:0] value,
                                                     input logic signed [5:0] limit);
      logic signed [5:0] res;
      if (value > limit) begin
         res = limit;
      end else if (value < -limit) begin
         res = -limit;
      end else begin
         res = value;
      end
      return res;
   endfunction

endpackage

// File: hw/rtl/cia_calc.sv
// Combinational date step: minute, hour and day adds with a single carry each.
// Depends on cia_pkg for the request and date types and the month lengths.
module cia_calc (
   input  cia_pkg::req_type  req,
   input  logic [4:0]        daily_hour,
   output cia_pkg::date_type result
);

   cia_pkg::date_type t;
   logic signed [5:0] min_clamp, hour_clamp, day_clamp;
   logic signed [7:0] min_sum, hour_sum, hour_step;
   logic signed [6:0] day_sum, day_step;
   logic              hour_en, day_en;
   logic [4:0]        len;
   logic [4:0]        month_next;

   assign min_clamp  = cia_pkg::clamp_step(req.interval, cia_pkg::MINUTE_STEP_MAX);
   assign hour_clamp = cia_pkg::clamp_step(req.interval, cia_pkg::HOUR_STEP_MAX);
   assign day_clamp  = cia_pkg::clamp_step(req.interval, cia_pkg::DAY_STEP_MAX);

   always_comb begin
      t         = req.date;
      hour_en   = 1'b0;
      day_en    = 1'b0;
      hour_step = '0;
      day_step  = '0;
      min_sum   = $signed({2'b00, req.date.minute}) + $signed({{2{min_clamp[5]}}, min_clamp});

      case (req.mode)
         cia_pkg::MODE_MINUTE: begin
            if (min_sum >= cia_pkg::MINUTES_PER_HOUR) begin
               t.minute  = 6'(min_sum - cia_pkg::MINUTES_PER_HOUR);
               hour_en   = 1'b1;
               hour_step = 8'sd1;
            end else if (min_sum < 8'sd0) begin
               t.minute  = 6'(min_sum + cia_pkg::MINUTES_PER_HOUR);
               hour_en   = 1'b1;
               hour_step = -8'sd1;
            end else begin
               t.minute = min_sum[5:0];
            end
            t.second = '0;
         end
         cia_pkg::MODE_HOUR: begin
            hour_en   = 1'b1;
            hour_step = $signed({{2{hour_clamp[5]}}, hour_clamp});
            t.minute  = '0;
            t.second  = '0;
         end
         cia_pkg::MODE_DAY: begin
            // The date only moves once the working day has begun.
            day_en   = (req.date.hour >= cia_pkg::DAY_STEP_HOUR);
            day_step = $signed({day_clamp[5], day_clamp});
            t.minute = '0;
            t.second = '0;
         end
         default: begin
         end
      endcase

      hour_sum = $signed({3'b000, t.hour}) + hour_step;
      if (hour_en) begin
         if (hour_sum >= cia_pkg::HOURS_PER_DAY) begin
            t.hour   = 5'(hour_sum - cia_pkg::HOURS_PER_DAY);
            day_en   = 1'b1;
            day_step = 7'sd1;
         end else if (hour_sum < 8'sd0) begin
            t.hour   = 5'(hour_sum + cia_pkg::HOURS_PER_DAY);
            day_en   = 1'b1;
            day_step = -7'sd1;
         end else begin
            t.hour = hour_sum[4:0];
         end
      end

      day_sum    = $signed({2'b00, t.day}) + day_step;
      len        = cia_pkg::month_length(t.month, t.year[1:0] == 2'b00);
      month_next = {1'b0, t.month} + 5'd1;
      if (day_en) begin
         if (day_sum > $signed({2'b00, len})) begin
            t.day = 5'd1;
            if (month_next > {1'b0, cia_pkg::MONTH_LAST}) begin
               t.month = cia_pkg::MONTH_FIRST;
               t.year  = (t.year >= cia_pkg::YEAR_MAX) ? 7'd0 : t.year + 7'd1;
            end else begin
               t.month = month_next[3:0];
            end
         end else if (day_sum <= 7'sd0) begin
            if (t.month <= cia_pkg::MONTH_FIRST) begin
               t.month = cia_pkg::MONTH_LAST;
               t.year  = (t.year == 7'd0) ? cia_pkg::YEAR_MAX : t.year - 7'd1;
            end else begin
               t.month = t.month - 4'd1;
            end
            // The borrowed day is the last day of the month now in place.
            t.day = cia_pkg::month_length(t.month, t.year[1:0] == 2'b00);
         end else begin
            t.day = day_sum[4:0];
         end
      end

      if (req.mode == cia_pkg::MODE_DAY) begin
         t.hour = daily_hour;
      end

      result = t;
   end

endmodule

// File: hw/rtl/calendar_interval_add.sv
// Top level of the calendar interval adder: input register, step logic and
// result register. Depends on cia_pkg and cia_calc.
//
// Usage:
//   A transaction is issued by raising start with the req_ fields valid; it is
//   taken at the rising edge where start is high and busy is low. busy is
//   never raised, so a transaction can be issued in every cycle.
//   The request is captured in an input register, the step logic works between
//   that register and the result register, and the result appears on the rsp_
//   ports with rsp_strobe high for exactly one cycle. Throughput is one
//   transaction per cycle, set by the single-pass step logic.
//   The receiver cannot stall; each result is shown once and must be taken.
//   csr_we with csr_wdata writes the daily hour used by day-mode steps; write
//   it only while no transaction is in flight.
//   A synchronous reset drops any transaction in flight and sets the daily
//   hour to 0.
module calendar_interval_add (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [1:0]        req_mode,
   input  logic signed [5:0] req_interval,
   input  logic [6:0]        req_year_in,
   input  logic [3:0]        req_month_in,
   input  logic [4:0]        req_day_in,
   input  logic [4:0]        req_hour_in,
   input  logic [5:0]        req_minute_in,
   input  logic [5:0]        req_second_in,
   output logic              rsp_strobe,
   output logic [6:0]        rsp_year_out,
   output logic [3:0]        rsp_month_out,
   output logic [4:0]        rsp_day_out,
   output logic [4:0]        rsp_hour_out,
   output logic [5:0]        rsp_minute_out,
   output logic [5:0]        rsp_second_out,
   input  logic              csr_we,
   input  logic [4:0]        csr_wdata
);

   logic              req_valid_ff, req_valid_in;
   cia_pkg::req_type  req_ff, req_in;
   logic              rsp_strobe_ff, rsp_strobe_in;
   cia_pkg::date_type rsp_ff, rsp_in;
   logic [4:0]        daily_hour_ff, daily_hour_in;

   assign busy = 1'b0;

   always_comb begin
      req_valid_in         = start && !busy;
      req_in.mode          = cia_pkg::mode_type'(req_mode);
      req_in.interval      = req_interval;
      req_in.date.year     = req_year_in;
      req_in.date.month    = req_month_in;
      req_in.date.day      = req_day_in;
      req_in.date.hour     = req_hour_in;
      req_in.date.minute   = req_minute_in;
      req_in.date.second   = req_second_in;
      rsp_strobe_in        = req_valid_ff;
      daily_hour_in        = csr_we ? csr_wdata : daily_hour_ff;
   end

   cia_calc u_calc (
      .req        (req_ff),
      .daily_hour (daily_hour_ff),
      .result     (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff  <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         daily_hour_ff <= 5'd0;
      end else begin
         req_valid_ff  <= req_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
         daily_hour_ff <= daily_hour_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_year_out   = rsp_ff.year;
   assign rsp_month_out  = rsp_ff.month;
   assign rsp_day_out    = rsp_ff.day;
   assign rsp_hour_out   = rsp_ff.hour;
   assign rsp_minute_out = rsp_ff.minute;
   assign rsp_second_out = rsp_ff.second;

endmodule

// File: hw/rtl/cia_checker.sv
// Port-level checks of calendar_interval_add, bound to the top level.
// Depends on cia_pkg for the mode codes.
module cia_port_checks (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic [1:0]        req_mode,
   input logic [6:0]        req_year_in,
   input logic [3:0]        req_month_in,
   input logic [4:0]        req_day_in,
   input logic [4:0]        req_hour_in,
   input logic [5:0]        req_minute_in,
   input logic [5:0]        req_second_in,
   input logic              rsp_strobe,
   input logic [6:0]        rsp_year_out,
   input logic [3:0]        rsp_month_out,
   input logic [4:0]        rsp_day_out,
   input logic [4:0]        rsp_hour_out,
   input logic [5:0]        rsp_minute_out,
   input logic [5:0]        rsp_second_out
);

   // Every accepted transaction yields a result.
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_strobe)
      else $error("accepted transaction produced no result");

   // No result appears without an accepted transaction.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, 2))
      else $error("result without an accepted transaction");

   // Hour mode clears minutes and seconds.
   a_hour_clears: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && $past(req_mode, 2) == cia_pkg::MODE_HOUR)
         |-> (rsp_minute_out == 6'd0 && rsp_second_out == 6'd0))
      else $error("hour mode left minutes or seconds set");

   // No-change mode passes the date and time through untouched.
   a_hold_passes: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && $past(req_mode, 2) == cia_pkg::MODE_HOLD)
         |-> (rsp_year_out == $past(req_year_in, 2) && rsp_month_out == $past(req_month_in, 2)
              && rsp_day_out == $past(req_day_in, 2) && rsp_hour_out == $past(req_hour_in, 2)
              && rsp_minute_out == $past(req_minute_in, 2)
              && rsp_second_out == $past(req_second_in, 2)))
      else $error("no-change mode altered the date or time");

endmodule

bind calendar_interval_add cia_port_checks u_cia_port_checks (.*);
